FILE: design/lprcb_pkg.sv
// Package: shared types, constants and the CORDIC arctangent table.
package lprcb_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned BrightW = 16;
  localparam int unsigned RingW = 5;
  localparam int unsigned ColW = 10;
  localparam int unsigned TimeW = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned SqW = 48;
  localparam int unsigned RootW = 33;
  localparam int unsigned VecW = 48;
  localparam int unsigned AngW = 34;

  localparam logic [CfgIdxW-1:0] CfgFovBottom = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRingStep = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNearLimit = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFramePeriod = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [BrightW-1:0] brightness;
  } point_t;

  typedef struct packed {
    logic kept;
    logic [RingW-1:0] ring_index;
    logic [ColW-1:0] column_index;
    logic [TimeW-1:0] time_offset;
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [BrightW-1:0] out_brightness;
  } result_t;

  typedef struct packed {
    logic signed [15:0] fov_bottom;
    logic [23:0] ring_step;
    logic [15:0] near_limit;
    logic [19:0] frame_period;
  } cfg_t;

  // one CORDIC lane: vector and accumulated angle
  typedef struct packed {
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [AngW-1:0] ang;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_turn(input int unsigned i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
      3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return $signed({2'b00, t});
  endfunction

endpackage

FILE: design/lprcb_if.sv
// Interfaces: valid/ready channels for points and results.
interface lprcb_point_if;
  import lprcb_pkg::*;
  logic valid;
  logic ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lprcb_result_if;
  import lprcb_pkg::*;
  logic valid;
  logic ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/lprcb_cordic_cell.sv
// One CORDIC vectoring cell: a single rotation with a register after it.
module lprcb_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic clk,
  input  logic en,
  input  lprcb_pkg::cordic_t d_in,
  output lprcb_pkg::cordic_t d_out
);
  import lprcb_pkg::*;

  cordic_t q_r, q_nxt;
  logic signed [VecW-1:0] sx, sy;

  always_comb begin
    // arithmetic shift floors, as required
    sx = d_in.vx >>> SHIFT;
    sy = d_in.vy >>> SHIFT;
    if (!d_in.vy[VecW-1]) begin
      q_nxt.vx = d_in.vx + sy;
      q_nxt.vy = d_in.vy - sx;
      q_nxt.ang = d_in.ang + atan_turn(SHIFT);
    end else begin
      q_nxt.vx = d_in.vx - sy;
      q_nxt.vy = d_in.vy + sx;
      q_nxt.ang = d_in.ang - atan_turn(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign d_out = q_r;
endmodule

FILE: design/lprcb_sqrt_cell.sv
// One restoring square-root cell: settles one result bit per cycle while en is high.
module lprcb_sqrt_cell #(
  parameter int unsigned BITPOS = 0
) (
  input  logic clk,
  input  logic en,
  input  logic [65:0] rem_in,
  input  logic [32:0] root_in,
  output logic [65:0] rem_out,
  output logic [32:0] root_out
);
  logic [65:0] rem_r, rem_nxt;
  logic [32:0] root_r, root_nxt;
  logic [65:0] trial;

  always_comb begin
    trial = ({33'd0, root_in} << (BITPOS + 1)) + (66'd1 << (2 * BITPOS));
    if (rem_in >= trial) begin
      rem_nxt = rem_in - trial;
      root_nxt = root_in | (33'd1 << BITPOS);
    end else begin
      rem_nxt = rem_in;
      root_nxt = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_out = rem_r;
  assign root_out = root_r;
endmodule

FILE: design/lprcb_div_cell.sv
// One restoring divider cell: one quotient bit per cycle while en is high.
module lprcb_div_cell #(
  parameter int unsigned BITPOS = 0,
  parameter int unsigned NW = 56,
  parameter int unsigned QW = 8
) (
  input  logic clk,
  input  logic en,
  input  logic [NW-1:0] num_in,
  input  logic [NW-1:0] den_in,
  input  logic [QW-1:0] q_in,
  output logic [NW-1:0] num_out,
  output logic [NW-1:0] den_out,
  output logic [QW-1:0] q_out
);
  logic [NW-1:0] num_r, num_nxt, den_r;
  logic [QW-1:0] q_r, q_nxt;
  logic [NW+QW-1:0] sh;

  always_comb begin
    sh = {{QW{1'b0}}, den_in} << BITPOS;
    if ({{QW{1'b0}}, num_in} >= sh) begin
      num_nxt = num_in - sh[NW-1:0];
      q_nxt = q_in | QW'(1 << BITPOS);
    end else begin
      num_nxt = num_in;
      q_nxt = q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= den_in;
      q_r <= q_nxt;
    end
  end

  assign num_out = num_r;
  assign den_out = den_r;
  assign q_out = q_r;
endmodule

FILE: design/lidar_point_ring_column_binning_top.sv
// Top level: lidar point ring and column binning pipeline.
// One point is accepted per cycle while ready is high, and one result leaves per point, in order.
// A point passes the square and sum registers, the square-root cell chain,
// the pitch CORDIC cell row, the divider cell row, the azimuth CORDIC cell
// row and the column, time and output registers; the whole chain shifts
// whenever the output register is free or taken, so a stalled result holds
// the pipeline and ready falls only while the output is full and not taken.
module lidar_point_ring_column_binning_top #(
  parameter int unsigned RINGS = 32,
  parameter int unsigned COLUMNS = 1024,
  parameter int unsigned CORDIC_STAGES = 18
) (
  input  logic clk,
  input  logic rst_n,
  lprcb_point_if.sink in_ch,
  lprcb_result_if.source out_ch,
  input  logic cfg_we,
  input  logic [lprcb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lprcb_pkg::CfgDataW-1:0] cfg_data
);
  import lprcb_pkg::*;

  localparam int unsigned NST = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int unsigned QW = $clog2(RINGS) + 1;
  localparam int unsigned NW = 64;
  localparam int unsigned COLW = $clog2(COLUMNS) + 1;
  localparam int unsigned LAT = 2 + 33 + NST + 1 + QW + NST + 3;

  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fov_bottom <= -16'sd5760;
      cfg_r.ring_step <= 24'd95147;
      cfg_r.near_limit <= 16'd41;
      cfg_r.frame_period <= 20'd100000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgFovBottom: cfg_r.fov_bottom <= cfg_data[15:0];
        CfgRingStep: cfg_r.ring_step <= cfg_data;
        CfgNearLimit: cfg_r.near_limit <= cfg_data[15:0];
        CfgFramePeriod: cfg_r.frame_period <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [LAT-1:0] vld_r;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  // point and pass flag travel alongside the arithmetic
  point_t pt_r [LAT];
  logic ok_r [LAT];
  logic okin;
  logic [CoordW-1:0] ax, ay;
  assign ax = in_ch.data.pos_x[CoordW-1] ? -in_ch.data.pos_x : in_ch.data.pos_x;
  assign ay = in_ch.data.pos_y[CoordW-1] ? -in_ch.data.pos_y : in_ch.data.pos_y;
  assign okin = (ax >= {8'd0, cfg_r.near_limit}) && (ay >= {8'd0, cfg_r.near_limit});

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r[0] <= in_ch.data;
      ok_r[0] <= okin;
      for (int i = 1; i < LAT; i++) begin
        pt_r[i] <= pt_r[i-1];
        ok_r[i] <= ok_r[i-1];
      end
    end
  end

  // stage 1/2: squares then sum
  logic [SqW-1:0] xx_r, yy_r;
  logic [65:0] sq_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r <= SqW'(pt_r[0].pos_x * pt_r[0].pos_x);
      yy_r <= SqW'(pt_r[0].pos_y * pt_r[0].pos_y);
    end
  end
  // note: squares registered from pt_r[0] land at index 1
  always_ff @(posedge clk) begin
    if (adv) sq_r <= {1'b0, ({1'b0, xx_r} + {1'b0, yy_r}), 16'd0};
  end

  // square-root cell chain, 33 bits; starts at index 2 -> after 33 at index 35
  logic [65:0] rem_w [34];
  logic [32:0] root_w [34];
  assign rem_w[0] = sq_r;
  assign root_w[0] = '0;
  for (genvar g = 0; g < 33; g++) begin : g_sqrt
    lprcb_sqrt_cell #(.BITPOS(32 - g)) u_c (
      .clk, .en(adv), .rem_in(rem_w[g]), .root_in(root_w[g] >> 0),
      .rem_out(rem_w[g+1]), .root_out(root_w[g+1]));
  end

  // pitch CORDIC: atan2(z*256, r); r >= 0 so no pre-rotation, origin gives 0
  localparam int unsigned P0 = 2 + 33;
  cordic_t pc [NST+1];
  logic porig;
  assign porig = (root_w[33] == 0) && (pt_r[P0].pos_z == 0);
  always_comb begin
    pc[0].vx = VecW'($signed({1'b0, root_w[33]})) <<< 8;
    pc[0].vy = VecW'(pt_r[P0].pos_z) <<< 16;
    pc[0].ang = '0;
  end
  logic porig_r [NST];
  for (genvar g = 0; g < NST; g++) begin : g_pc
    lprcb_cordic_cell #(.SHIFT(g)) u_c (.clk, .en(adv), .d_in(pc[g]), .d_out(pc[g+1]));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      porig_r[0] <= porig;
      for (int i = 1; i < NST; i++) porig_r[i] <= porig_r[i-1];
    end
  end

  // numerator and divisor, one register
  localparam int unsigned D0 = P0 + NST;
  logic signed [AngW-1:0] pang;
  logic signed [NW-1:0] num_s, d_s;
  logic [NW-1:0] num_r, den_r;
  logic neg_r;
  assign pang = porig_r[NST-1] ? '0 : pc[NST].ang;
  always_comb begin
    d_s = NW'((cfg_r.ring_step == 0) ? 24'd1 : cfg_r.ring_step) <<< 13;
    num_s = ((NW'(pang) * 45) - (NW'(cfg_r.fov_bottom) <<< 21)) * 2 + d_s;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r <= num_s[NW-1];
      num_r <= num_s;
      den_r <= d_s <<< 1;
    end
  end

  // divider cells; quotients too large for the cell row set an overflow flag that drops the point
  logic [NW-1:0] dn [QW+1], dd [QW+1];
  logic [QW-1:0] dq [QW+1];
  logic ovf, ovf_r [QW], neg_p [QW];
  assign ovf = ({64'd0, num_r} >= ({64'd0, den_r} << QW));
  assign dn[0] = num_r;
  assign dd[0] = den_r;
  assign dq[0] = '0;
  for (genvar g = 0; g < QW; g++) begin : g_div
    lprcb_div_cell #(.BITPOS(QW - 1 - g), .NW(NW), .QW(QW)) u_c (
      .clk, .en(adv), .num_in(dn[g]), .den_in(dd[g]), .q_in(dq[g]),
      .num_out(dn[g+1]), .den_out(dd[g+1]), .q_out(dq[g+1]));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0] <= ovf;
      neg_p[0] <= neg_r;
      for (int i = 1; i < QW; i++) begin
        ovf_r[i] <= ovf_r[i-1];
        neg_p[i] <= neg_p[i-1];
      end
    end
  end

  // azimuth CORDIC, with half-turn pre-rotation
  localparam int unsigned A0 = D0 + 1 + QW;
  cordic_t ac [NST+1];
  logic aorig, aorig_r [NST], rok_r [NST];
  logic [RingW-1:0] rg_r [NST];
  logic ringok;
  logic signed [VecW-1:0] ex, ey;
  assign ringok = !neg_p[QW-1] && !ovf_r[QW-1] && (dq[QW] < QW'(RINGS));
  always_comb begin
    ex = VecW'(pt_r[A0].pos_x) <<< 16;
    ey = VecW'(pt_r[A0].pos_y) <<< 16;
    aorig = (pt_r[A0].pos_x == 0) && (pt_r[A0].pos_y == 0);
    if (pt_r[A0].pos_x[CoordW-1]) begin
      ac[0].vx = -ex;
      ac[0].vy = -ey;
      ac[0].ang = pt_r[A0].pos_y[CoordW-1] ? -(AngW'(1) <<< 31) : (AngW'(1) <<< 31);
    end else begin
      ac[0].vx = ex;
      ac[0].vy = ey;
      ac[0].ang = '0;
    end
  end
  for (genvar g = 0; g < NST; g++) begin : g_ac
    lprcb_cordic_cell #(.SHIFT(g)) u_c (.clk, .en(adv), .d_in(ac[g]), .d_out(ac[g+1]));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      aorig_r[0] <= aorig;
      rok_r[0] <= ringok;
      rg_r[0] <= RingW'(dq[QW]);
      for (int i = 1; i < NST; i++) begin
        aorig_r[i] <= aorig_r[i-1];
        rok_r[i] <= rok_r[i-1];
        rg_r[i] <= rg_r[i-1];
      end
    end
  end

  // column, then time offset, then output register
  localparam int unsigned C0 = A0 + NST;
  logic [31:0] u;
  logic [COLW+31:0] cprod;
  logic [COLW-1:0] colraw;
  logic [COLW-2:0] col_r;
  logic keep_r, keep2_r;
  logic [RingW-1:0] rg2_r, rg3_r;
  logic [COLW+19:0] tprod_r;
  logic [COLW-2:0] col2_r;
  assign u = (aorig_r[NST-1] ? 32'd0 : ac[NST].ang[31:0]) + 32'h8000_0000;
  assign cprod = ({{COLW{1'b0}}, u} * (COLW+32)'(COLUMNS)) + (COLW+32)'(33'h8000_0000);
  assign colraw = cprod[COLW+31:32];
  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= (colraw >= COLW'(COLUMNS)) ? '0 : colraw[COLW-2:0];
      keep_r <= ok_r[C0] && rok_r[NST-1];
      rg2_r <= rg_r[NST-1];
      tprod_r <= (COLW+20)'(col_r) * (COLW+20)'(cfg_r.frame_period);
      col2_r <= col_r;
      keep2_r <= keep_r;
      rg3_r <= rg2_r;
    end
  end

  // divide by COLUMNS as a reciprocal multiply, exact for products below 2^32
  localparam int unsigned RSH = 32 + $clog2(COLUMNS);
  localparam logic [32:0] TREC =
    33'((((65'd1 << RSH) + 65'(COLUMNS)) - 65'd1) / 65'(COLUMNS));
  logic [COLW+52:0] tq;
  assign tq = (COLW+53)'(tprod_r) * (COLW+53)'(TREC);

  result_t res_r;
  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= vld_r[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.kept <= keep2_r;
      res_r.ring_index <= keep2_r ? rg3_r : '0;
      res_r.column_index <= keep2_r ? ColW'(col2_r) : '0;
      res_r.time_offset <= keep2_r ? TimeW'(tq >> RSH) : '0;
      res_r.out_x <= pt_r[LAT-1].pos_x;
      res_r.out_y <= pt_r[LAT-1].pos_y;
      res_r.out_z <= pt_r[LAT-1].pos_z;
      res_r.out_brightness <= pt_r[LAT-1].brightness;
    end
  end
  assign out_ch.valid = ov_r;
  assign out_ch.data = res_r;
endmodule

FILE: design/lprcb_checker.sv
// Port checker for the binning block, bound to the top level.
module lprcb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_kept,
  input logic [4:0] out_ring,
  input logic [9:0] out_col,
  input logic [19:0] out_time
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stall without pending result");
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kept |-> out_ring == 0 && out_col == 0 && out_time == 0)
    else $error("dropped point carries bins");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind lidar_point_ring_column_binning_top lprcb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kept(out_ch.data.kept),
  .out_ring(out_ch.data.ring_index), .out_col(out_ch.data.column_index),
  .out_time(out_ch.data.time_offset));
